[hdl/wcc2d_pkg.sv]
// Shared types and constants of the 2D window cross-correlation block.
`default_nettype none
package wcc2d_pkg;

  localparam int MAX_KERNEL  = 8;
  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int KIDX_BITS   = $clog2(MAX_KERNEL);
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = COL_BITS + 1;
  localparam int KSIZE_BITS  = KIDX_BITS + 1;
  localparam int ROW_BITS    = 16;
  localparam int RESULT_BITS = 40;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int HIST_BITS   = (MAX_KERNEL - 1) * SAMPLE_BITS;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_HEIGHT = 2'd3;

  // Item codes
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          func;
    logic [2:0]                    weight_row;
    logic [2:0]                    weight_col;
    logic signed [SAMPLE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] result;
    logic [9:0]                    out_x;
    logic [15:0]                   out_y;
    logic                          last;
  } out_t;

endpackage
`default_nettype wire

[hdl/window_cross_correlation_2d_top.sv]
// Top level of the 2D valid cross-correlation block with line store and result queue.
`default_nettype none
// Accepts one item (weight load or image sample) per clock cycle. Each sample
// does one read of the line store memory at its column and writes the column
// history back in the next cycle, so successive samples overlap; a one-column
// image hits the same entry back to back and is served by forwarding. A result
// passes in order through the read, the window shift, 64 parallel products and
// the row sums, and its final sum is formed as it enters an eight-entry result
// queue; input ready drops only while eight results are pending, so with a
// free output the rate is one item per cycle. There is no clearing pass after
// reset. Weight loads take effect for every sample that follows them.
module window_cross_correlation_2d_top
  import wcc2d_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_t                     in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_t                         out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data
);

  localparam int QDEPTH = 8;
  localparam int QBITS  = $clog2(QDEPTH);

  // Configuration registers
  logic [WIDTH_BITS-1:0] image_width;
  logic [15:0]           image_height;
  logic [3:0]            kernel_width;
  logic [3:0]            kernel_height;

  // Effective sizes
  logic [WIDTH_BITS-1:0] w_eff;
  logic [16:0]           h_eff;
  logic [KSIZE_BITS-1:0] kw_eff;
  logic [KSIZE_BITS-1:0] kh_eff;

  // Positions
  logic [COL_BITS-1:0] col_pos;
  logic [ROW_BITS-1:0] row_pos;

  // Stage 1
  logic                          s1_v;
  logic                          s1_func;
  logic [2:0]                    s1_wr;
  logic [2:0]                    s1_wc;
  logic signed [SAMPLE_BITS-1:0] s1_value;
  logic                          s1_emit;
  logic [COL_BITS-1:0]           s1_col;
  logic                          s1_fwd;
  logic [9:0]                    s1_x;
  logic [15:0]                   s1_y;
  logic                          s1_last;

  // Line store
  logic [HIST_BITS-1:0] line_mem [MAX_WIDTH];
  logic [HIST_BITS-1:0] rdata;
  logic [HIST_BITS-1:0] last_wdata;
  logic [HIST_BITS-1:0] hist;
  logic [HIST_BITS-1:0] wdata;

  // Weights and window
  logic signed [SAMPLE_BITS-1:0] wt   [MAX_KERNEL][MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] wmap [MAX_KERNEL][MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] win  [MAX_KERNEL][MAX_KERNEL];

  // Later stages
  logic                        s2_v;
  logic [9:0]                  s2_x;
  logic [15:0]                 s2_y;
  logic                        s2_last;
  logic signed [PROD_BITS-1:0] prod [MAX_KERNEL][MAX_KERNEL];
  logic                        s3_v;
  logic [9:0]                  s3_x;
  logic [15:0]                 s3_y;
  logic                        s3_last;
  logic signed [RESULT_BITS-1:0] rowsum [MAX_KERNEL];
  logic                        s4_v;
  logic [9:0]                  s4_x;
  logic [15:0]                 s4_y;
  logic                        s4_last;

  // Result queue
  out_t             q_mem [QDEPTH];
  logic [QBITS-1:0] q_wp;
  logic [QBITS-1:0] q_rp;
  logic [QBITS:0]   q_cnt;
  logic [QBITS:0]   pending;

  logic in_xfer;
  logic out_xfer;
  logic samp_xfer;
  logic emit;
  logic [9:0]  x0;
  logic [15:0] y0;
  logic        last_samp;
  logic        col_end;
  logic        row_end;

  // Clamp configuration to its usable range
  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (image_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? 17'd1 : {1'b0, image_height};
    if (kernel_width == '0) begin
      kw_eff = KSIZE_BITS'(1);
    end else if (kernel_width > 4'(MAX_KERNEL)) begin
      kw_eff = KSIZE_BITS'(MAX_KERNEL);
    end else begin
      kw_eff = KSIZE_BITS'(kernel_width);
    end
    if (kernel_height == '0) begin
      kh_eff = KSIZE_BITS'(1);
    end else if (kernel_height > 4'(MAX_KERNEL)) begin
      kh_eff = KSIZE_BITS'(MAX_KERNEL);
    end else begin
      kh_eff = KSIZE_BITS'(kernel_height);
    end
  end

  assign in_ready  = (pending < (QBITS+1)'(QDEPTH));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (q_cnt != '0);
  assign out_xfer  = out_valid && out_ready;
  assign out_data  = q_mem[q_rp];
  assign samp_xfer = in_xfer && (in_data.func == FUNC_SAMPLE);

  // Window decision for the incoming sample
  always_comb begin
    emit = ({1'b0, col_pos} + WIDTH_BITS'(1) >= WIDTH_BITS'(kw_eff)) &&
           ({1'b0, row_pos} + 17'd1 >= 17'(kh_eff));
    x0 = 10'(col_pos - COL_BITS'(kw_eff - KSIZE_BITS'(1)));
    y0 = row_pos - ROW_BITS'(kh_eff - KSIZE_BITS'(1));
    col_end = ({1'b0, col_pos} + WIDTH_BITS'(1) >= w_eff);
    row_end = ({1'b0, row_pos} + 17'd1 >= h_eff);
    last_samp = col_end && row_end;
  end

  // Configuration writes and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_BITS'(1024);
      image_height  <= 16'd1024;
      kernel_width  <= 4'd3;
      kernel_height <= 4'd3;
      col_pos       <= '0;
      row_pos       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[15:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        default: ;
      endcase
      col_pos <= '0;
      row_pos <= '0;
    end else if (samp_xfer) begin
      if (col_end) begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_pos + ROW_BITS'(1);
      end else begin
        col_pos <= col_pos + COL_BITS'(1);
      end
    end
  end

  // Stage 1 capture and line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_xfer;
    end
    s1_func  <= in_data.func;
    s1_wr    <= in_data.weight_row;
    s1_wc    <= in_data.weight_col;
    s1_value <= in_data.value;
    s1_emit  <= emit;
    s1_col   <= col_pos;
    s1_x     <= x0;
    s1_y     <= y0;
    s1_last  <= last_samp;
    s1_fwd   <= s1_v && (s1_func == FUNC_SAMPLE) && (s1_col == col_pos);
    if (samp_xfer) begin
      rdata <= line_mem[col_pos];
    end
  end

  // Column history: forward the word written last cycle on a same-column hit
  assign hist  = s1_fwd ? last_wdata : rdata;
  assign wdata = {hist[HIST_BITS-SAMPLE_BITS-1:0], s1_value};

  always_ff @(posedge clk) begin
    if (s1_v && (s1_func == FUNC_SAMPLE)) begin
      line_mem[s1_col] <= wdata;
      last_wdata       <= wdata;
    end
  end

  // Weight writes and window shift in item order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int c = 0; c < MAX_KERNEL; c++) begin
          wt[r][c]  <= '0;
          win[r][c] <= '0;
        end
      end
    end else if (s1_v) begin
      if (s1_func == FUNC_WEIGHT) begin
        wt[s1_wr][s1_wc] <= s1_value;
      end else begin
        for (int b = 0; b < MAX_KERNEL; b++) begin
          for (int a = 1; a < MAX_KERNEL; a++) begin
            win[b][a] <= win[b][a-1];
          end
        end
        win[0][0] <= s1_value;
        for (int b = 1; b < MAX_KERNEL; b++) begin
          win[b][0] <= hist[(b-1)*SAMPLE_BITS +: SAMPLE_BITS];
        end
      end
    end
  end

  // Map weights onto window ages (row age b, column age a)
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
          wmap[b][a] <= '0;
        end
      end
    end else begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
          if ((KSIZE_BITS'(b) < kh_eff) && (KSIZE_BITS'(a) < kw_eff)) begin
            wmap[b][a] <= wt[KIDX_BITS'(kh_eff - KSIZE_BITS'(1) - KSIZE_BITS'(b))]
                            [KIDX_BITS'(kw_eff - KSIZE_BITS'(1) - KSIZE_BITS'(a))];
          end else begin
            wmap[b][a] <= '0;
          end
        end
      end
    end
  end

  // Products, row sums, final sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s2_v <= s1_v && (s1_func == FUNC_SAMPLE) && s1_emit;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    s2_x <= s1_x;  s2_y <= s1_y;  s2_last <= s1_last;
    s3_x <= s2_x;  s3_y <= s2_y;  s3_last <= s2_last;
    s4_x <= s3_x;  s4_y <= s3_y;  s4_last <= s3_last;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
        prod[b][a] <= win[b][a] * wmap[b][a];
      end
    end
    for (int b = 0; b < MAX_KERNEL; b++) begin
      logic signed [RESULT_BITS-1:0] acc;
      acc = '0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
        acc = acc + RESULT_BITS'(prod[b][a]);
      end
      rowsum[b] <= acc;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    logic signed [RESULT_BITS-1:0] total;
    total = '0;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      total = total + rowsum[b];
    end
    if (rst) begin
      q_wp    <= '0;
      q_rp    <= '0;
      q_cnt   <= '0;
      pending <= '0;
    end else begin
      if (s4_v) begin
        q_wp <= q_wp + QBITS'(1);
      end
      if (out_xfer) begin
        q_rp <= q_rp + QBITS'(1);
      end
      q_cnt   <= q_cnt + (QBITS+1)'(s4_v) - (QBITS+1)'(out_xfer);
      pending <= pending + (QBITS+1)'(samp_xfer && emit) - (QBITS+1)'(out_xfer);
    end
    if (s4_v) begin
      q_mem[q_wp] <= '{result: total, out_x: s4_x, out_y: s4_y, last: s4_last};
    end
  end

  // Checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (QBITS+1)'(QDEPTH))
    else $error("pending results exceed queue depth");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= pending)
    else $error("queue holds more results than pending");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (col_pos == '0) && (row_pos == '0))
    else $error("configuration write did not restart the image");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> $past(s1_v))
    else $error("forwarding without a preceding write");

endmodule
`default_nettype wire

[bench/wcc2d_checker.sv]
// Result predictor and scoreboard for the 2D window cross-correlation block.
`timescale 1ns / 1ps
module wcc2d_checker
  import wcc2d_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire in_t                     in_data,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire out_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  output int                           fail_count,
  output int                           pending
);

  logic [10:0] img_w;
  logic [15:0] img_h;
  logic [3:0]  ker_w;
  logic [3:0]  ker_h;
  logic signed [15:0] lines [MAX_KERNEL][MAX_WIDTH];
  logic signed [15:0] weights [MAX_KERNEL][MAX_KERNEL];
  int col_pos;
  int row_pos;
  out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Advance the image model by one sample and queue its window sum, if any
  task automatic predict_sample(logic signed [15:0] v);
    int w, h, kw, kh, c, r, x0, y0;
    logic signed [39:0] acc;
    out_t o;
    w = clamp(img_w, MAX_WIDTH);
    h = clamp(img_h, 65535);
    kw = clamp(ker_w, MAX_KERNEL);
    kh = clamp(ker_h, MAX_KERNEL);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    lines[r % MAX_KERNEL][c] = v;
    if (c + 1 >= kw && r + 1 >= kh) begin
      x0 = c + 1 - kw;
      y0 = r + 1 - kh;
      acc = '0;
      for (int l = 0; l < kh; l++)
        for (int k = 0; k < kw; k++)
          acc += 40'(lines[(y0 + l) % MAX_KERNEL][x0 + k] * weights[l][k]);
      o.result = acc;
      o.out_x = x0[9:0];
      o.out_y = y0[15:0];
      o.last = (c == w - 1 && r == h - 1);
      expected_results.push_back(o);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // Track configuration, inputs and results on every rising edge
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      img_w = 1024; img_h = 1024; ker_w = 3; ker_h = 3;
      col_pos = 0; row_pos = 0;
      foreach (weights[i, j]) weights[i][j] = '0;
      foreach (lines[i, j]) lines[i][j] = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   img_w = cfg_data[10:0];
          REG_IMAGE_HEIGHT:  img_h = cfg_data[15:0];
          REG_KERNEL_WIDTH:  ker_w = cfg_data[3:0];
          REG_KERNEL_HEIGHT: ker_h = cfg_data[3:0];
          default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(out_data.result), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_data.result !== want.result)
            report("result", 64'(out_data.result), 64'(want.result));
          if (out_data.out_x !== want.out_x)
            report("out_x", 64'(out_data.out_x), 64'(want.out_x));
          if (out_data.out_y !== want.out_y)
            report("out_y", 64'(out_data.out_y), 64'(want.out_y));
          if (out_data.last !== want.last)
            report("last", 64'(out_data.last), 64'(want.last));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_WEIGHT)
          weights[in_data.weight_row][in_data.weight_col] = in_data.value;
        else
          predict_sample(in_data.value);
      end
    end
  end

endmodule

[bench/tb_window_cross_correlation_2d_top.sv]
// Stimulus and verdict for the 2D window cross-correlation block.
`timescale 1ns / 1ps
module tb_window_cross_correlation_2d_top;
  import wcc2d_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycle_count = 0;
  bit out_stall_on = 1'b1;

  window_cross_correlation_2d_top dut (.*);

  wcc2d_checker checker_i (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Randomly stall the result side
  always @(negedge clk) begin
    if (!out_stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 65);
  end

  // Drop valid over a gap, then hold the item until its transfer
  task automatic send(logic f, logic [2:0] r, logic [2:0] c, logic [15:0] v, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: f, weight_row: r, weight_col: c, value: v};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  // Drain results, then let the pipeline settle before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic setup(int w, int h, int kw, int kh);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
    write_reg(REG_KERNEL_WIDTH, 16'(kw));
    write_reg(REG_KERNEL_HEIGHT, 16'(kh));
    cfg_we <= 1'b0;
  endtask

  task automatic load_kernel(bit gaps);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send(FUNC_WEIGHT, 3'(r), 3'(c), 16'($urandom), gaps);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n, w, h, kw, kh, sent;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme weights and samples, 1x1 kernel on a tiny image
    setup(2, 2, 1, 1);
    send(FUNC_WEIGHT, 0, 0, 16'h8000, 0);
    send(FUNC_SAMPLE, 7, 7, 16'h8000, 0);
    send(FUNC_SAMPLE, 0, 0, 16'h7fff, 0);
    send(FUNC_WEIGHT, 0, 0, 16'h7fff, 0);
    send(FUNC_SAMPLE, 0, 0, 16'h8000, 0);
    send(FUNC_SAMPLE, 0, 0, 16'hffff, 0);
    // 8x8 kernel with its last weight row at an extreme value on an 8x9 image
    setup(8, 9, 8, 8);
    for (int i = 0; i < 8; i++) send(FUNC_WEIGHT, 7, 3'(i), 16'h8000, 0);
    for (int i = 0; i < 72; i++) send(FUNC_SAMPLE, 0, 0, 16'h8000, 0);
    // Zero and oversized register values map to the clamped range
    setup(0, 0, 0, 0);
    send(FUNC_SAMPLE, 0, 0, 16'h1234, 0);
    send(FUNC_SAMPLE, 0, 0, 16'h8000, 0);
    setup(2047, 3, 15, 15);
    send(FUNC_SAMPLE, 0, 0, 16'h7fff, 0);
    // Kernel larger than the image gives nothing
    setup(2, 2, 3, 3);
    for (int i = 0; i < 4; i++) send(FUNC_SAMPLE, 0, 0, 16'h4000, 0);

    // Random images, mostly small, one at full width
    sent = 0;
    n = 0;
    while (sent < 1500) begin
      kw = $urandom_range(1, 8);
      kh = $urandom_range(1, 8);
      w = $urandom_range(kw, kw + 10);
      h = $urandom_range(kh, kh + 6);
      if (n == 1) begin w = 1024; h = 1; kw = 8; kh = 1; end
      if (n % 13 == 5) begin w = 1; h = $urandom_range(1, 20); kw = 1; kh = 1; end
      if (n % 11 == 3) kw = w + 1;
      out_stall_on = (n % 4 != 2);
      setup((n == 2) ? 0 : w, h, kw, kh);
      load_kernel(1);
      sent += 64;
      for (int i = 0; i < w * h; i++) begin
        // Occasionally retune one weight mid-image
        if ($urandom_range(0, 40) == 0) begin
          send(FUNC_WEIGHT, 3'($urandom), 3'($urandom), pick_value(), 1);
          sent++;
        end
        send(FUNC_SAMPLE, 3'($urandom), 3'($urandom), pick_value(), n % 5 != 1);
        sent++;
      end
      n++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
